@@ sv/vbd_pkg.sv @@
// Shared types and constants of the variable-byte posting list decoder.
// Used by the channel interfaces, the decode stage and the top level.
// No dependencies.
package vbd_pkg;

    // Default configuration of the decoder
    localparam int MAX_VALUE_BYTES_DEF = 5;
    localparam int ID_WIDTH_DEF        = 32;

    // Fixed field widths of the channels
    localparam int BYTE_W = 8;
    localparam int OUT_W  = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    // Terminator flag position and payload group width of one code byte
    localparam int END_BIT = 7;
    localparam int GROUP_W = 7;

    // Which value of the list comes next
    typedef enum logic [1:0] {
        PH_WORD = 2'd0,
        PH_GAP  = 2'd1,
        PH_FREQ = 2'd2,
        PH_IDLE = 2'd3
    } t_phase;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_OVERLONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] word_id;
        logic [OUT_W-1:0] docid;
        logic [OUT_W-1:0] frequency;
        t_status          status;
    } t_out_item;

endpackage

@@ sv/vbd_if.sv @@
// Valid/ready channel interfaces of the posting list decoder.
// Depends on vbd_pkg for the byte and result payload types.
interface vbd_in_if;
    import vbd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface vbd_out_if;
    import vbd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/vbd_decode.sv @@
// Decode stage: list state registers and the per-byte variable-byte decode.
// Depends on vbd_pkg; driven by the top level one registered byte per step.
module vbd_decode #(
    parameter int MAX_VALUE_BYTES = vbd_pkg::MAX_VALUE_BYTES_DEF,
    parameter int ID_WIDTH        = vbd_pkg::ID_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  vbd_pkg::t_in_item             i_item,
    input  logic [vbd_pkg::CFG_W-1:0]     i_min_docid,
    output logic                          o_emit,
    output vbd_pkg::t_out_item            o_result
);
    import vbd_pkg::*;

    localparam logic [IDX_W:0] MAX_CNT = (IDX_W+1)'(MAX_VALUE_BYTES);

    logic [ID_WIDTH-1:0] r_accum, n_accum;
    logic [IDX_W-1:0]    r_idx, n_idx;
    t_phase              r_phase, n_phase;
    logic [ID_WIDTH-1:0] r_prev, n_prev;
    logic [ID_WIDTH-1:0] r_pending, n_pending;
    logic [ID_WIDTH-1:0] r_word, n_word;

    // State as seen by this byte, after a list start clears it
    logic [ID_WIDTH-1:0] c_accum, c_prev, c_pending, c_word;
    logic [IDX_W-1:0]    c_idx;
    t_phase              c_phase;

    logic [5:0]          shift;
    logic [ID_WIDTH-1:0] group;
    logic [ID_WIDTH-1:0] value;
    logic [ID_WIDTH-1:0] docid_sum;
    logic [IDX_W:0]      idx_inc;

    // Clear list state on the first byte of a list
    always_comb begin
        if (i_item.first_byte) begin
            c_accum   = '0;
            c_idx     = '0;
            c_phase   = PH_WORD;
            c_prev    = '0;
            c_pending = '0;
            c_word    = '0;
        end else begin
            c_accum   = r_accum;
            c_idx     = r_idx;
            c_phase   = r_phase;
            c_prev    = r_prev;
            c_pending = r_pending;
            c_word    = r_word;
        end
    end

    // Place the 7-bit group at 7 * byte index, keep the low id bits
    assign shift     = {c_idx, 3'b000} - {3'b000, c_idx};
    assign group     = ID_WIDTH'(i_item.data_byte[GROUP_W-1:0]) << shift;
    assign value     = c_accum | group;
    assign docid_sum = c_prev + value;
    assign idx_inc   = {1'b0, c_idx} + (IDX_W+1)'(1);

    // Next state and result for one byte
    always_comb begin
        n_accum   = c_accum;
        n_idx     = c_idx;
        n_phase   = c_phase;
        n_prev    = c_prev;
        n_pending = c_pending;
        n_word    = c_word;
        o_emit    = 1'b0;
        o_result  = '{word_id: OUT_W'(c_word), docid: '0, frequency: '0, status: ST_OK};

        if (c_phase != PH_IDLE) begin
            if (!i_item.data_byte[END_BIT]) begin
                if (idx_inc >= MAX_CNT) begin
                    // Drop an overlong value and stop the list
                    n_phase         = PH_IDLE;
                    n_accum         = '0;
                    n_idx           = '0;
                    o_emit          = 1'b1;
                    o_result.status = ST_OVERLONG;
                end else if (i_item.last_byte) begin
                    // List ends inside a value
                    n_phase         = PH_IDLE;
                    n_accum         = '0;
                    n_idx           = '0;
                    o_emit          = 1'b1;
                    o_result.status = ST_TRUNC;
                end else begin
                    n_accum = value;
                    n_idx   = idx_inc[IDX_W-1:0];
                end
            end else begin
                n_accum = '0;
                n_idx   = '0;
                case (c_phase)
                    PH_WORD: begin
                        n_word  = value;
                        n_phase = i_item.last_byte ? PH_IDLE : PH_GAP;
                    end
                    PH_GAP: begin
                        n_pending = docid_sum;
                        n_prev    = docid_sum;
                        if (i_item.last_byte) begin
                            // Gap without its frequency
                            n_phase         = PH_IDLE;
                            o_emit          = 1'b1;
                            o_result.status = ST_TRUNC;
                        end else begin
                            n_phase = PH_FREQ;
                        end
                    end
                    PH_FREQ: begin
                        n_phase = i_item.last_byte ? PH_IDLE : PH_GAP;
                        if (CFG_W'(c_pending) >= i_min_docid) begin
                            o_emit             = 1'b1;
                            o_result.docid     = OUT_W'(c_pending);
                            o_result.frequency = OUT_W'(value);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Advance list state once per decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum   <= '0;
            r_idx     <= '0;
            r_phase   <= PH_WORD;
            r_prev    <= '0;
            r_pending <= '0;
            r_word    <= '0;
        end else if (i_step) begin
            r_accum   <= n_accum;
            r_idx     <= n_idx;
            r_phase   <= n_phase;
            r_prev    <= n_prev;
            r_pending <= n_pending;
            r_word    <= n_word;
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_idx} < MAX_CNT)
        else $error("byte index reached the value byte limit");

    a_error_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_emit && o_result.status != ST_OK |=> r_phase == PH_IDLE)
        else $error("list not idle after an error result");

    a_skip_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_emit && o_result.status == ST_OK |-> o_result.docid >= i_min_docid)
        else $error("pair below the skip target emitted");

endmodule

@@ sv/varbyte_posting_decoder_unit.sv @@
// Top level of the variable-byte posting list decoder: channel registers,
// skip target register and the decode stage. Depends on vbd_pkg, vbd_if, vbd_decode.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+--------------------------------------------
//   i_in    | in  | valid / ready    | data_byte[7:0], first_byte, last_byte
//   o_out   | out | valid / ready    | word_id, docid, frequency [31:0], status[1:0]
//   i_cfg   | in  | i_cfg_we         | i_cfg_wdata[31:0] -> min_docid
//
// One byte per cycle sustained while o_out does not stall; a byte's result, if it has one,
// leaves through the input register and then the result register.
// The decode between them is one shift, one OR, one 32-bit add and a compare.
// A stall on o_out holds both registers; i_in.ready stays high while the
// result register can move or the input register is empty.
// i_rst_n is synchronous, active low; it empties both registers, clears list
// state and sets the skip target to zero.
module varbyte_posting_decoder_unit #(
    parameter int MAX_VALUE_BYTES = vbd_pkg::MAX_VALUE_BYTES_DEF,
    parameter int ID_WIDTH        = vbd_pkg::ID_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    vbd_in_if.sink                    i_in,
    vbd_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [vbd_pkg::CFG_W-1:0] i_cfg_wdata
);
    import vbd_pkg::*;

    logic             r_in_valid;
    t_in_item         r_in;
    logic             r_out_valid;
    t_out_item        r_out;
    logic [CFG_W-1:0] r_min_docid;

    logic      advance;
    logic      step;
    logic      accept;
    logic      emit;
    t_out_item result;

    // Move when the result register is free or being taken
    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;
    assign accept     = i_in.valid && i_in.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Skip target register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_docid <= '0;
        end else if (i_cfg_we) begin
            r_min_docid <= i_cfg_wdata;
        end
    end

    // Input register: capture a request, release it on a step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in.payload;
        end
    end

    vbd_decode #(
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES),
        .ID_WIDTH        (ID_WIDTH)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .i_min_docid (r_min_docid),
        .o_emit      (emit),
        .o_result    (result)
    );

    // Result register: load a result, hold it while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_OK |-> r_out.docid == '0 && r_out.frequency == '0)
        else $error("error result carries a pair");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("pending byte lost during a stall");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("result overwritten while stalled");

endmodule
